[design/tccc_pkg.sv]
package tccc_pkg;

    // Screen geometry and blink period
    localparam int COLUMNS     = 102;
    localparam int ROWS        = 40;
    localparam int BLINK_TICKS = 50;

    // Field widths
    localparam int COL_W    = 7;
    localparam int ROW_W    = 6;
    localparam int TICK_W   = 6;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 32;
    localparam int ACTION_W = 2;
    localparam int CFG_IDX_W = 2;

    // Commands per input item
    localparam int MAX_CMDS = 4;
    localparam int CMD_IDX_W = $clog2(MAX_CMDS);
    localparam int CMD_CNT_W = $clog2(MAX_CMDS + 1);

    // Control characters
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam int TAB_STOP = 8;

    // Reset values of the configuration registers
    localparam logic [COLOR_W-1:0] FG_RESET = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] BG_RESET = 32'h0000_0000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PRINT      = 2'd0,
        ACT_TICK       = 2'd1,
        ACT_SET_CURSOR = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CMD_BAR    = 2'd0,
        CMD_GLYPH  = 2'd1,
        CMD_ERASE  = 2'd2,
        CMD_SCROLL = 2'd3
    } command_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOREGROUND = 2'd0,
        CFG_BACKGROUND = 2'd1,
        CFG_ENABLED    = 2'd2
    } cfg_index_t;

    typedef struct packed {
        command_t             command;
        logic [CHAR_W-1:0]    glyph;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic [COLOR_W-1:0]   color;
    } cmd_t;

    typedef struct packed {
        cmd_t [MAX_CMDS-1:0]  cmds;
        logic [CMD_CNT_W-1:0] count;
    } batch_t;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              shown;
        logic [TICK_W-1:0] ticks;
    } cursor_t;

    typedef struct packed {
        logic [COLOR_W-1:0] fg;
        logic [COLOR_W-1:0] bg;
        logic               enabled;
    } config_t;

endpackage

[design/text_console_cursor_controller.sv]
// Text console cursor controller.
// Input channel (s_*): one console event per transaction: print a character,
// timer tick, or set the cursor position. Output channel (m_*): drawing
// commands for a blitter, one per transaction, m_last marking the final
// command of an event. Configuration channel (cfg_*): writes foreground
// color, background color and enable; always ready, to be used while idle.
// An accepted event is decoded in the same cycle and its one to four
// commands are stored as a batch; a batch is offered once the older batch
// has left, and one command leaves per cycle while m_ready is high. Events
// that draw nothing (ticks that do not toggle, disabled block, ignored moves)
// store no batch. Two batches are held: a new event is taken while the
// previous batch is still draining, so a steady stream is bounded by the
// single output port.
// When the receiver stalls, the current command holds and input stops once
// both batch slots are full.
// Reset: cursor at column 0 row 0, shown, blink counter 0, block disabled,
// foreground all ones, background zero, no commands pending.
module text_console_cursor_controller
    import tccc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ACTION_W-1:0]  s_action,
    input  logic [CHAR_W-1:0]    s_char_code,
    input  logic [COL_W-1:0]     s_target_col,
    input  logic [ROW_W-1:0]     s_target_row,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_command,
    output logic [CHAR_W-1:0]    m_glyph_code,
    output logic [COL_W-1:0]     m_cell_col,
    output logic [ROW_W-1:0]     m_cell_row,
    output logic [COLOR_W-1:0]   m_color,
    output logic                 m_last,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    config_t  cfg_reg;
    cursor_t  cursor_reg;
    cursor_t  cursor_next;
    batch_t   plan_batch;
    batch_t   slot_reg [2];
    logic     wr_ptr_reg;
    logic     rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic [CMD_IDX_W-1:0] idx_reg;
    batch_t   head;
    cmd_t     head_cmd;
    logic     s_fire;
    logic     m_fire;
    logic     push;
    logic     pop;

    tccc_plan u_plan (
        .action     (s_action),
        .char_code  (s_char_code),
        .target_col (s_target_col),
        .target_row (s_target_row),
        .cur        (cursor_reg),
        .cfg        (cfg_reg),
        .nxt        (cursor_next),
        .batch      (plan_batch)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (fill_reg != 2'd2);
    assign s_fire    = s_valid && s_ready;
    assign push      = s_fire && (plan_batch.count != '0);

    // Present the current command of the oldest batch
    assign head     = slot_reg[rd_ptr_reg];
    assign head_cmd = head.cmds[idx_reg];
    assign m_valid  = (fill_reg != 2'd0);
    assign m_command    = head_cmd.command;
    assign m_glyph_code = head_cmd.glyph;
    assign m_cell_col   = head_cmd.col;
    assign m_cell_row   = head_cmd.row;
    assign m_color      = head_cmd.color;
    assign m_last       = (CMD_CNT_W'(idx_reg) + CMD_CNT_W'(1) == head.count);
    assign m_fire       = m_valid && m_ready;
    assign pop          = m_fire && m_last;

    assign fill_next = fill_reg + {1'b0, push} - {1'b0, pop};

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fg      <= FG_RESET;
            cfg_reg.bg      <= BG_RESET;
            cfg_reg.enabled <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_FOREGROUND: cfg_reg.fg      <= cfg_data;
                CFG_BACKGROUND: cfg_reg.bg      <= cfg_data;
                CFG_ENABLED:    cfg_reg.enabled <= cfg_data[0];
                default:        cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // Cursor state advances on every accepted transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg.col   <= '0;
            cursor_reg.row   <= '0;
            cursor_reg.shown <= 1'b1;
            cursor_reg.ticks <= '0;
        end else if (s_fire) begin
            cursor_reg <= cursor_next;
        end
    end

    // Store a new batch
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= plan_batch;
        end
    end

    // Batch queue pointers and command index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            idx_reg    <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
                idx_reg    <= '0;
            end else if (m_fire) begin
                idx_reg <= idx_reg + CMD_IDX_W'(1);
            end
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 2'd2)
        else $error("batch queue overflow");

    a_head_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (head.count != '0 && CMD_CNT_W'(idx_reg) < head.count))
        else $error("command index beyond batch");

    a_idx_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (idx_reg == '0))
        else $error("command index not restarted after last command");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cursor_reg.col < COL_W'(COLUMNS)) && (cursor_reg.row < ROW_W'(ROWS)))
        else $error("cursor left the screen");

endmodule

[design/tccc_plan.sv]
module tccc_plan
    import tccc_pkg::*;
(
    input  logic [ACTION_W-1:0] action,
    input  logic [CHAR_W-1:0]   char_code,
    input  logic [COL_W-1:0]    target_col,
    input  logic [ROW_W-1:0]    target_row,
    input  cursor_t             cur,
    input  config_t             cfg,
    output cursor_t             nxt,
    output batch_t              batch
);

    function automatic cmd_t make_cmd(command_t c, logic [CHAR_W-1:0] g,
                                      logic [COL_W-1:0] x, logic [ROW_W-1:0] y,
                                      logic [COLOR_W-1:0] clr);
        cmd_t r;
        r.command = c;
        r.glyph   = g;
        r.col     = x;
        r.row     = y;
        r.color   = clr;
        return r;
    endfunction

    // Work out the new cursor state and the command list for one item
    always_comb begin
        logic [COL_W:0]     col8;
        logic [ROW_W:0]     row7;
        logic [TICK_W:0]    tick7;
        logic [CMD_CNT_W-1:0] n;

        nxt   = cur;
        batch = '0;
        n     = '0;
        col8  = {1'b0, cur.col};
        row7  = {1'b0, cur.row};
        tick7 = {1'b0, cur.ticks} + (TICK_W+1)'(1);

        unique case (action)
            ACT_TICK: begin
                if (tick7 >= (TICK_W+1)'(BLINK_TICKS)) begin
                    nxt.ticks = '0;
                    nxt.shown = ~cur.shown;
                    if (cfg.enabled) begin
                        batch.cmds[0] = make_cmd(CMD_BAR, '0, cur.col, cur.row,
                                                 cur.shown ? cfg.bg : cfg.fg);
                        n = CMD_CNT_W'(1);
                    end
                end else begin
                    nxt.ticks = tick7[TICK_W-1:0];
                end
            end
            ACT_PRINT: begin
                if (cfg.enabled) begin
                    // hide the bar at the old place
                    batch.cmds[0] = make_cmd(CMD_BAR, '0, cur.col, cur.row, cfg.bg);
                    n = CMD_CNT_W'(1);
                    priority if (char_code == CHAR_NEWLINE) begin
                        col8 = '0;
                        row7 = row7 + (ROW_W+1)'(1);
                    end else if (char_code == CHAR_RETURN) begin
                        col8 = '0;
                    end else if (char_code == CHAR_TAB) begin
                        col8 = (col8 + (COL_W+1)'(TAB_STOP))
                             & ~(COL_W+1)'(TAB_STOP - 1);
                    end else if (char_code == CHAR_BACKSPACE) begin
                        if (col8 != '0) begin
                            col8 = col8 - (COL_W+1)'(1);
                            batch.cmds[n[CMD_IDX_W-1:0]] =
                                make_cmd(CMD_ERASE, '0, col8[COL_W-1:0], cur.row, cfg.bg);
                            n = n + CMD_CNT_W'(1);
                        end
                    end else begin
                        batch.cmds[n[CMD_IDX_W-1:0]] =
                            make_cmd(CMD_GLYPH, char_code, cur.col, cur.row, cfg.fg);
                        n    = n + CMD_CNT_W'(1);
                        col8 = col8 + (COL_W+1)'(1);
                    end
                    // wrap to the next line
                    if (col8 >= (COL_W+1)'(COLUMNS)) begin
                        col8 = '0;
                        row7 = row7 + (ROW_W+1)'(1);
                    end
                    // scroll when the cursor falls off the bottom
                    if (row7 >= (ROW_W+1)'(ROWS)) begin
                        batch.cmds[n[CMD_IDX_W-1:0]] =
                            make_cmd(CMD_SCROLL, '0, '0, ROW_W'(ROWS - 1), cfg.bg);
                        n    = n + CMD_CNT_W'(1);
                        row7 = row7 - (ROW_W+1)'(1);
                    end
                    nxt.col   = col8[COL_W-1:0];
                    nxt.row   = row7[ROW_W-1:0];
                    nxt.shown = 1'b1;
                    batch.cmds[n[CMD_IDX_W-1:0]] =
                        make_cmd(CMD_BAR, '0, col8[COL_W-1:0], row7[ROW_W-1:0], cfg.fg);
                    n = n + CMD_CNT_W'(1);
                end
            end
            ACT_SET_CURSOR: begin
                if (cfg.enabled && target_col < COL_W'(COLUMNS)
                    && target_row < ROW_W'(ROWS)) begin
                    batch.cmds[0] = make_cmd(CMD_BAR, '0, cur.col, cur.row, cfg.bg);
                    batch.cmds[1] = make_cmd(CMD_BAR, '0, target_col, target_row, cfg.fg);
                    n         = CMD_CNT_W'(2);
                    nxt.col   = target_col;
                    nxt.row   = target_row;
                    nxt.shown = 1'b1;
                end
            end
            default: begin
                n = '0;
            end
        endcase

        batch.count = n;
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import tccc_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int REPORT_LIMIT  = 10;

    // One drawing command as it leaves the block
    typedef struct packed {
        cmd_t cmd;
        logic last;
    } draw_t;

    // One row of the directed plan: a register write or an event
    typedef struct packed {
        logic                is_cfg;
        cfg_index_t          cfg_idx;
        logic [COLOR_W-1:0]  cfg_val;
        logic [ACTION_W-1:0] act;
        logic [CHAR_W-1:0]   ch;
        logic [COL_W-1:0]    tcol;
        logic [ROW_W-1:0]    trow;
        logic [7:0]          reps;
        logic                chk;
        logic [2:0]          n;
        draw_t               fin;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ACTION_W-1:0]  s_action = '0;
    logic [CHAR_W-1:0]    s_char_code = '0;
    logic [COL_W-1:0]     s_target_col = '0;
    logic [ROW_W-1:0]     s_target_row = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b1;
    logic [1:0]           m_command;
    logic [CHAR_W-1:0]    m_glyph_code;
    logic [COL_W-1:0]     m_cell_col;
    logic [ROW_W-1:0]     m_cell_row;
    logic [COLOR_W-1:0]   m_color;
    logic                 m_last;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLOR_W-1:0]   cfg_data = '0;

    // Console state as the predictor sees it
    logic [COL_W-1:0]     cur_col = '0;
    logic [ROW_W-1:0]     cur_row = '0;
    logic                 cur_shown = 1'b1;
    logic [TICK_W-1:0]    blink_count = '0;
    logic [COLOR_W-1:0]   pred_fg = FG_RESET;
    logic [COLOR_W-1:0]   pred_bg = BG_RESET;
    logic                 disp_en = 1'b0;

    draw_t                staged_cmds[$];
    draw_t                pending_draws[$];
    plan_row_t            plan[$];
    int                   pred_n;
    draw_t                pred_fin;

    int                   send_idle = 0;
    int                   recv_stall = 0;
    int                   fail_count = 0;
    int                   events_sent = 0;
    int                   ticks_sent = 0;
    int                   blink_toggles = 0;
    int                   phases_run = 0;
    int                   cmd_seen[4] = '{0, 0, 0, 0};

    text_console_cursor_controller u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_char_code  (s_char_code),
        .s_target_col (s_target_col),
        .s_target_row (s_target_row),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_command    (m_command),
        .m_glyph_code (m_glyph_code),
        .m_cell_col   (m_cell_col),
        .m_cell_row   (m_cell_row),
        .m_color      (m_color),
        .m_last       (m_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic string fmt_draw(draw_t d);
        return $sformatf("cmd=%0d glyph=%02h cell=(%0d,%0d) color=%08h last=%0d",
                         d.cmd.command, d.cmd.glyph, d.cmd.col, d.cmd.row,
                         d.cmd.color, d.last);
    endfunction

    function automatic void flag(string what, draw_t want, draw_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, what);
            $display("    expected %s", fmt_draw(want));
            $display("    actual   %s", fmt_draw(got));
        end
    endfunction

    // Queue one predicted command for the event being worked out
    function automatic void stage(command_t cmd, logic [CHAR_W-1:0] g, int col, int row,
                                  logic [COLOR_W-1:0] color);
        draw_t d;
        d.cmd.command = cmd;
        d.cmd.glyph   = g;
        d.cmd.col     = COL_W'(col);
        d.cmd.row     = ROW_W'(row);
        d.cmd.color   = color;
        d.last        = 1'b0;
        staged_cmds.push_back(d);
    endfunction

    // Advance the console state by one event and queue the commands it draws
    function automatic void predict_event(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                                          logic [COL_W-1:0] tc, logic [ROW_W-1:0] tr);
        int col;
        int row;
        int t;
        staged_cmds.delete();
        if (act == ACT_TICK) begin
            t = int'(blink_count) + 1;
            if (t >= BLINK_TICKS) begin
                blink_count = '0;
                cur_shown = ~cur_shown;
                blink_toggles++;
                if (disp_en)
                    stage(CMD_BAR, '0, int'(cur_col), int'(cur_row),
                          cur_shown ? pred_fg : pred_bg);
            end else begin
                blink_count = TICK_W'(t);
            end
        end else if (act == ACT_PRINT && disp_en) begin
            // hide the bar, apply the character, wrap, scroll, show the bar
            stage(CMD_BAR, '0, int'(cur_col), int'(cur_row), pred_bg);
            col = int'(cur_col);
            row = int'(cur_row);
            if (ch == CHAR_NEWLINE) begin
                col = 0;
                row++;
            end else if (ch == CHAR_RETURN) begin
                col = 0;
            end else if (ch == CHAR_TAB) begin
                col = (col + TAB_STOP) & ~(TAB_STOP - 1);
            end else if (ch == CHAR_BACKSPACE) begin
                if (col > 0) begin
                    col--;
                    stage(CMD_ERASE, '0, col, row, pred_bg);
                end
            end else begin
                stage(CMD_GLYPH, ch, col, row, pred_fg);
                col++;
            end
            if (col >= COLUMNS) begin
                col = 0;
                row++;
            end
            if (row >= ROWS) begin
                stage(CMD_SCROLL, '0, 0, ROWS - 1, pred_bg);
                row--;
            end
            cur_col = COL_W'(col);
            cur_row = ROW_W'(row);
            cur_shown = 1'b1;
            stage(CMD_BAR, '0, int'(cur_col), int'(cur_row), pred_fg);
        end else if (act == ACT_SET_CURSOR && disp_en && int'(tc) < COLUMNS
                     && int'(tr) < ROWS) begin
            stage(CMD_BAR, '0, int'(cur_col), int'(cur_row), pred_bg);
            cur_col = tc;
            cur_row = tr;
            cur_shown = 1'b1;
            stage(CMD_BAR, '0, int'(cur_col), int'(cur_row), pred_fg);
        end
        pred_n = staged_cmds.size();
        pred_fin = '0;
        if (pred_n > 0) begin
            staged_cmds[pred_n - 1].last = 1'b1;
            pred_fin = staged_cmds[pred_n - 1];
        end
        foreach (staged_cmds[i])
            pending_draws.push_back(staged_cmds[i]);
    endfunction

    // Offer one event, hold it until accepted, then predict its commands
    task automatic send_event(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                              logic [COL_W-1:0] tc, logic [ROW_W-1:0] tr);
        if (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid      <= 1'b1;
        s_action     <= act;
        s_char_code  <= ch;
        s_target_col <= tc;
        s_target_row <= tr;
        do @(posedge aclk); while (!s_ready);
        predict_event(act, ch, tc, tr);
        events_sent++;
        if (act == ACT_TICK)
            ticks_sent++;
    endtask

    // Drop valid and wait until every predicted command has come out
    task automatic settle();
        int k;
        s_valid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && pending_draws.size() > 0; k++)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [COLOR_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FOREGROUND: pred_fg = val;
            CFG_BACKGROUND: pred_bg = val;
            CFG_ENABLED:    disp_en = val[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] next_char();
        int r;
        r = $urandom_range(99);
        if (r < 12)
            return CHAR_NEWLINE;
        if (r < 20)
            return CHAR_RETURN;
        if (r < 30)
            return CHAR_TAB;
        if (r < 42)
            return CHAR_BACKSPACE;
        return CHAR_W'($urandom_range(255));
    endfunction

    task automatic send_print();
        send_event(ACT_PRINT, next_char(), COL_W'($urandom_range(127)),
                   ROW_W'($urandom_range(63)));
    endtask

    // Plan builders for the directed part
    function automatic void plan_cfg(cfg_index_t idx, logic [COLOR_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        plan.push_back(r);
    endfunction

    function automatic void plan_evt(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                                     int tc, int tr, int reps);
        plan_row_t r;
        r = '0;
        r.act  = act;
        r.ch   = ch;
        r.tcol = COL_W'(tc);
        r.trow = ROW_W'(tr);
        r.reps = 8'(reps);
        plan.push_back(r);
    endfunction

    // Event whose command count and closing cursor bar are known by hand
    function automatic void plan_chk(logic [ACTION_W-1:0] act, logic [CHAR_W-1:0] ch,
                                     int tc, int tr, int n, int bcol, int brow,
                                     logic [COLOR_W-1:0] bcolor);
        plan_row_t r;
        r = '0;
        r.act  = act;
        r.ch   = ch;
        r.tcol = COL_W'(tc);
        r.trow = ROW_W'(tr);
        r.reps = 8'd1;
        r.chk  = 1'b1;
        r.n    = 3'(n);
        r.fin.cmd.command = CMD_BAR;
        r.fin.cmd.col     = COL_W'(bcol);
        r.fin.cmd.row     = ROW_W'(brow);
        r.fin.cmd.color   = bcolor;
        r.fin.last        = 1'b1;
        plan.push_back(r);
    endfunction

    // Random traffic under one register setting and one idling mix
    task automatic run_phase(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg, logic en,
                             int sidle, int rstall, int items, bit hold_mid);
        int sent;
        int pick;
        int tc;
        int tr;
        bit held;
        settle();
        write_reg(CFG_FOREGROUND, fg);
        write_reg(CFG_BACKGROUND, bg);
        write_reg(CFG_ENABLED, {{(COLOR_W-1){1'b0}}, en});
        send_idle = sidle;
        recv_stall = rstall;
        phases_run++;
        sent = 0;
        held = 0;
        while (sent < items) begin
            // pause the sender once until the output side runs dry
            if (hold_mid && !held && sent >= items / 2) begin
                settle();
                held = 1;
            end
            pick = $urandom_range(99);
            if (pick < 30) begin
                // jump near the right edge or bottom row, then type
                tc = $urandom_range(1) ? COLUMNS - 1 - $urandom_range(9)
                                       : $urandom_range(COLUMNS - 1);
                tr = $urandom_range(1) ? ROWS - 1 - $urandom_range(1)
                                       : $urandom_range(ROWS - 1);
                send_event(ACT_SET_CURSOR, CHAR_W'($urandom_range(255)), COL_W'(tc),
                           ROW_W'(tr));
                sent++;
                repeat ($urandom_range(1, 8)) begin
                    send_print();
                    sent++;
                end
            end else if (pick < 33) begin
                // run of ticks around the length of a blink period
                repeat ($urandom_range(45, 55)) begin
                    send_event(ACT_TICK, CHAR_W'($urandom_range(255)),
                               COL_W'($urandom_range(127)), ROW_W'($urandom_range(63)));
                    sent++;
                end
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 6)) begin
                    send_print();
                    sent++;
                end
            end else begin
                send_event(ACTION_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
                           COL_W'($urandom_range(127)), ROW_W'($urandom_range(63)));
                sent++;
            end
        end
    endtask

    // Receiver: stall at the rate of the current phase
    always @(posedge aclk) begin
        m_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end

    // Compare each command transaction with the oldest prediction
    always @(posedge aclk) begin
        draw_t got;
        draw_t want;
        if (aresetn && m_valid && m_ready) begin
            got.cmd.command = command_t'(m_command);
            got.cmd.glyph   = m_glyph_code;
            got.cmd.col     = m_cell_col;
            got.cmd.row     = m_cell_row;
            got.cmd.color   = m_color;
            got.last        = m_last;
            cmd_seen[m_command]++;
            if (pending_draws.size() == 0) begin
                flag("command with none predicted", '0, got);
            end else begin
                want = pending_draws.pop_front();
                if (got.cmd.command !== want.cmd.command || got.cmd.glyph !== want.cmd.glyph
                    || got.cmd.col !== want.cmd.col || got.cmd.row !== want.cmd.row
                    || got.cmd.color !== want.cmd.color || got.last !== want.last)
                    flag("command mismatch", want, got);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d commands outstanding", pending_draws.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        plan_row_t st;
        // disabled: prints and moves draw nothing, a tick only counts
        plan_chk(ACT_PRINT, 8'h41, 0, 0, 0, 0, 0, '0);
        plan_chk(ACT_SET_CURSOR, 8'h00, 5, 5, 0, 0, 0, '0);
        plan_chk(ACT_TICK, 8'h00, 0, 0, 0, 0, 0, '0);
        plan_cfg(CFG_ENABLED, 32'd1);
        // glyphs at the code extremes, backspace, return, tab
        plan_chk(ACT_PRINT, 8'h41, 0, 0, 3, 1, 0, FG_RESET);
        plan_chk(ACT_PRINT, 8'hFF, 0, 0, 3, 2, 0, FG_RESET);
        plan_chk(ACT_PRINT, 8'h00, 127, 63, 3, 3, 0, FG_RESET);
        plan_chk(ACT_PRINT, CHAR_BACKSPACE, 0, 0, 3, 2, 0, FG_RESET);
        plan_chk(ACT_PRINT, CHAR_RETURN, 0, 0, 2, 0, 0, FG_RESET);
        plan_chk(ACT_PRINT, CHAR_BACKSPACE, 0, 0, 2, 0, 0, FG_RESET);
        plan_chk(ACT_PRINT, CHAR_TAB, 0, 0, 2, 8, 0, FG_RESET);
        // wrap at the last column
        plan_chk(ACT_SET_CURSOR, 8'h00, COLUMNS - 1, 0, 2, COLUMNS - 1, 0, FG_RESET);
        plan_chk(ACT_PRINT, 8'h5A, 0, 0, 3, 0, 1, FG_RESET);
        // tab past the last column on the bottom row scrolls
        plan_chk(ACT_SET_CURSOR, 8'h00, COLUMNS - 2, ROWS - 1, 2, COLUMNS - 2, ROWS - 1,
                 FG_RESET);
        plan_chk(ACT_PRINT, CHAR_TAB, 0, 0, 3, 0, ROWS - 1, FG_RESET);
        plan_chk(ACT_PRINT, CHAR_NEWLINE, 0, 0, 3, 0, ROWS - 1, FG_RESET);
        // out-of-range moves and the unused action are dropped
        plan_chk(ACT_SET_CURSOR, 8'h00, COLUMNS, 0, 0, 0, 0, '0);
        plan_chk(ACT_SET_CURSOR, 8'h00, 0, ROWS, 0, 0, 0, '0);
        plan_chk(ACT_SET_CURSOR, 8'hFF, 127, 63, 0, 0, 0, '0);
        plan_chk(ACT_UNUSED, 8'hFF, 127, 63, 0, 0, 0, '0);
        // swapped color extremes
        plan_cfg(CFG_FOREGROUND, 32'h0000_0000);
        plan_cfg(CFG_BACKGROUND, 32'hFFFF_FFFF);
        plan_chk(ACT_SET_CURSOR, 8'h00, 0, 0, 2, 0, 0, 32'h0000_0000);
        plan_evt(ACT_PRINT, 8'h78, 0, 0, 1);
        plan_evt(ACT_PRINT, CHAR_NEWLINE, 0, 0, 1);
        // fill the blink period, the next tick hides the bar
        plan_evt(ACT_TICK, 8'h00, 0, 0, BLINK_TICKS - 2);
        plan_chk(ACT_TICK, 8'h00, 0, 0, 1, 0, 1, 32'hFFFF_FFFF);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // walk the directed plan
        foreach (plan[i]) begin
            st = plan[i];
            if (st.is_cfg) begin
                settle();
                write_reg(st.cfg_idx, st.cfg_val);
            end else begin
                repeat (st.reps) begin
                    send_event(st.act, st.ch, st.tcol, st.trow);
                    if (st.chk && (pred_n != int'(st.n)
                                   || (st.n != 0 && pred_fin !== st.fin)))
                        flag($sformatf("directed row %0d: %0d commands, plan says %0d",
                                       i, pred_n, st.n), st.fin, pred_fin);
                end
            end
        end

        run_phase($urandom(), $urandom(), 1'b1, 0, 0, 45, 0);
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 73, 0, 45, 1);
        run_phase(FG_RESET, BG_RESET, 1'b1, 0, 73, 45, 0);
        run_phase($urandom(), $urandom(), 1'b1, 14, 14, 45, 0);
        run_phase($urandom(), $urandom(), 1'b0, 14, 14, 30, 0);
        run_phase($urandom(), $urandom(), 1'b1, 0, 0, 35, 0);

        settle();
        if (pending_draws.size() > 0) begin
            fail_count += pending_draws.size();
            $display("ERROR: %0d predicted commands never came out", pending_draws.size());
        end

        $display("Sent %0d console events (%0d ticks, %0d blink toggles) over %0d phases",
                 events_sent, ticks_sent, blink_toggles, phases_run + 1);
        $display("Drew %0d cursor bars, %0d glyphs, %0d erases, %0d scrolls",
                 cmd_seen[CMD_BAR], cmd_seen[CMD_GLYPH], cmd_seen[CMD_ERASE],
                 cmd_seen[CMD_SCROLL]);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
design/tccc_pkg.sv
design/tccc_plan.sv
design/text_console_cursor_controller.sv
tb/sv/tb.sv
